/* hdl/mafe_pkg.sv */
// Package for the moving average forecast error unit.
// Field widths, sizing defaults and register indexes shared by the unit's files.
// No dependencies.
package mafe_pkg;

   localparam int PRICE_W         = 24;
   localparam int WLEN_W          = 8;
   localparam int ABS_SUM_W       = 41;
   localparam int SQ_SUM_W        = 64;
   localparam int MSE_W           = 48;
   localparam int CSR_DATA_W      = 8;
   localparam int CSR_INDEX_W     = 1;
   localparam int DIV_CNT_W       = $clog2(SQ_SUM_W + 1);

   localparam int WINDOW_MAX_DEF  = 128;
   localparam int SERIES_MAX_DEF  = 65536;
   localparam int WINDOW_LEN_RST  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEN    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHTED_MODE = 1'b1;

endpackage

/* hdl/mafe_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used for the sample ring of the forecast error unit.
module mafe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/moving_average_forecast_error_unit.sv */
// Moving average forecast error unit; depends on mafe_pkg and the mafe_ram sample ring.
// Each item passes the read, update and accumulate states, then the divider when it is needed,
// then the output step; the divider forms the window average, and on the series end the
// error means. One item is taken at a time; the output register lets the next item start
// while a result is stalled.
// Reset is synchronous and active high: clears the series, window_len to 5, weighted_mode to 0.
module moving_average_forecast_error_unit
   import mafe_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int SERIES_MAX = SERIES_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PRICE_W-1:0]     req_price,
   input  logic                   req_series_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PRICE_W-1:0]     rsp_average,
   output logic                   rsp_average_valid,
   output logic [PRICE_W-1:0]     rsp_mean_abs_error,
   output logic [MSE_W-1:0]       rsp_mean_sq_error,
   output logic                   rsp_stats_valid
);

   localparam int IDX_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
   localparam int PSUM_W = PRICE_W + CNT_W;
   localparam int WSUM_W = PRICE_W + 2 * CNT_W;
   localparam int PROD_W = PRICE_W + CNT_W;
   localparam int WT_W   = 2 * CNT_W;
   localparam int PAIR_W = $clog2(SERIES_MAX + 1);
   localparam int DIVR_W = (PAIR_W > WT_W) ? PAIR_W : WT_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_UPDATE = 6'b000100,
      S_ACCUM  = 6'b001000,
      S_DIV    = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      OP_AVG = 2'd0,
      OP_MAE = 2'd1,
      OP_MSE = 2'd2
   } div_op_type;

   state_type             state_ff, state_in;
   logic [WLEN_W-1:0]     window_len_ff, window_len_in;
   logic                  weighted_mode_ff, weighted_mode_in;
   logic [PRICE_W-1:0]    price_ff, price_in;
   logic                  last_ff, last_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [IDX_W-1:0]      write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]      fill_count_ff, fill_count_in;
   logic [PSUM_W-1:0]     plain_sum_ff, plain_sum_in;
   logic [WSUM_W-1:0]     weighted_sum_ff, weighted_sum_in;
   logic [PRICE_W-1:0]    forecast_ff, forecast_in;
   logic                  forecast_valid_ff, forecast_valid_in;
   logic [ABS_SUM_W-1:0]  abs_sum_ff, abs_sum_in;
   logic [SQ_SUM_W-1:0]   sq_sum_ff, sq_sum_in;
   logic [PAIR_W-1:0]     pair_count_ff, pair_count_in;
   logic [PRICE_W-1:0]    err_ff, err_in;
   logic [MSE_W-1:0]      sq_err_ff, sq_err_in;
   logic [PROD_W-1:0]     wprod_ff, wprod_in;
   logic [WT_W-1:0]       wtot_ff, wtot_in;
   logic                  avg_ok_ff, avg_ok_in;
   logic                  stats_ok_ff, stats_ok_in;
   div_op_type            div_op_ff, div_op_in;
   logic [SQ_SUM_W-1:0]   dvd_ff, dvd_in;
   logic [DIVR_W-1:0]     rem_ff, rem_in;
   logic [DIVR_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [PRICE_W-1:0]    res_avg_ff, res_avg_in;
   logic [PRICE_W-1:0]    res_mae_ff, res_mae_in;
   logic [MSE_W-1:0]      res_mse_ff, res_mse_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PRICE_W-1:0]    rsp_average_ff, rsp_average_in;
   logic                  rsp_average_valid_ff, rsp_average_valid_in;
   logic [PRICE_W-1:0]    rsp_mae_ff, rsp_mae_in;
   logic [MSE_W-1:0]      rsp_mse_ff, rsp_mse_in;
   logic                  rsp_stats_valid_ff, rsp_stats_valid_in;

   logic [CMP_W-1:0]      wl_ext;
   logic [CNT_W-1:0]      eff_n;
   logic                  filling;
   logic [CNT_W-1:0]      fill_next;
   logic [CNT_W-1:0]      wmult;
   logic [PRICE_W-1:0]    ring_rdata;
   logic                  ring_rd_en;
   logic                  ring_wr_en;
   logic                  req_accept;
   logic                  rsp_load;
   logic                  clear_series;
   logic                  start_div;
   div_op_type            start_op;
   logic                  score;
   logic [ABS_SUM_W:0]    abs_total;
   logic [SQ_SUM_W:0]     sq_total;
   logic [DIVR_W:0]       trial;
   logic                  trial_ge;
   logic [WSUM_W-1:0]     avg_dividend;

   mafe_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (slot_ff),
      .wr_data (price_ff),
      .rd_en   (ring_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ring_rdata)
   );

   // Effective window length: zero acts as one, large values clip to the ring size.
   always_comb begin
      wl_ext = CMP_W'(window_len_ff);
      if (wl_ext == '0) begin
         wl_ext = CMP_W'(1);
      end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
         wl_ext = CMP_W'(WINDOW_MAX);
      end
      eff_n = wl_ext[CNT_W-1:0];
   end

   assign filling    = fill_count_ff < eff_n;
   assign fill_next  = fill_count_ff + CNT_W'(1);
   assign wmult      = filling ? fill_next : eff_n;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign ring_rd_en = (state_ff == S_READ);
   assign ring_wr_en = (state_ff == S_UPDATE);
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign score      = forecast_valid_ff && (pair_count_ff < PAIR_W'(SERIES_MAX));
   assign abs_total  = {1'b0, abs_sum_ff} + (ABS_SUM_W + 1)'(err_ff);
   assign sq_total   = {1'b0, sq_sum_ff} + (SQ_SUM_W + 1)'(sq_err_ff);
   assign trial      = {rem_ff, dvd_ff[SQ_SUM_W-1]};
   assign trial_ge   = trial >= {1'b0, divisor_ff};
   assign avg_dividend = weighted_mode_ff ? weighted_sum_ff : WSUM_W'(plain_sum_ff);

   always_comb begin
      state_in          = state_ff;
      window_len_in     = window_len_ff;
      weighted_mode_in  = weighted_mode_ff;
      price_in          = price_ff;
      last_in           = last_ff;
      slot_in           = slot_ff;
      write_slot_in     = write_slot_ff;
      fill_count_in     = fill_count_ff;
      plain_sum_in      = plain_sum_ff;
      weighted_sum_in   = weighted_sum_ff;
      forecast_in       = forecast_ff;
      forecast_valid_in = forecast_valid_ff;
      abs_sum_in        = abs_sum_ff;
      sq_sum_in         = sq_sum_ff;
      pair_count_in     = pair_count_ff;
      err_in            = err_ff;
      sq_err_in         = sq_err_ff;
      wprod_in          = wprod_ff;
      wtot_in           = wtot_ff;
      avg_ok_in         = avg_ok_ff;
      stats_ok_in       = stats_ok_ff;
      div_op_in         = div_op_ff;
      dvd_in            = dvd_ff;
      rem_in            = rem_ff;
      divisor_in        = divisor_ff;
      div_cnt_in        = div_cnt_ff;
      res_avg_in        = res_avg_ff;
      res_mae_in        = res_mae_ff;
      res_mse_in        = res_mse_ff;
      start_div         = 1'b0;
      start_op          = OP_AVG;
      clear_series      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               price_in = req_price;
               last_in  = req_series_end;
               slot_in  = (CNT_W'(write_slot_ff) >= eff_n) ? '0 : write_slot_ff;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // The ring read is in flight; prepare the error and the weight product.
            err_in   = (price_ff >= forecast_ff) ? (price_ff - forecast_ff)
                                                 : (forecast_ff - price_ff);
            wprod_in = PROD_W'(wmult) * PROD_W'(price_ff);
            wtot_in  = WT_W'((WT_W'(eff_n) * (WT_W'(eff_n) + WT_W'(1))) >> 1);
            state_in = S_READ == state_ff ? S_UPDATE : state_ff;
         end
         S_UPDATE: begin
            sq_err_in = MSE_W'(err_ff) * MSE_W'(err_ff);
            if (filling) begin
               plain_sum_in    = plain_sum_ff + PSUM_W'(price_ff);
               weighted_sum_in = weighted_sum_ff + WSUM_W'(wprod_ff);
               fill_count_in   = fill_next;
               avg_ok_in       = fill_next >= eff_n;
            end else begin
               // The oldest sample leaves; every other weight drops by one.
               weighted_sum_in = weighted_sum_ff - WSUM_W'(plain_sum_ff) + WSUM_W'(wprod_ff);
               plain_sum_in    = plain_sum_ff - PSUM_W'(ring_rdata) + PSUM_W'(price_ff);
               avg_ok_in       = 1'b1;
            end
            write_slot_in = ((CNT_W'(slot_ff) + CNT_W'(1)) >= eff_n) ? '0
                                                                     : slot_ff + IDX_W'(1);
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            if (score) begin
               abs_sum_in    = abs_total[ABS_SUM_W] ? '1 : abs_total[ABS_SUM_W-1:0];
               sq_sum_in     = sq_total[SQ_SUM_W] ? '1 : sq_total[SQ_SUM_W-1:0];
               pair_count_in = pair_count_ff + PAIR_W'(1);
            end
            stats_ok_in = last_ff && (pair_count_in != '0);
            if (avg_ok_ff) begin
               start_div = 1'b1;
               start_op  = OP_AVG;
            end else if (last_ff && (pair_count_in != '0)) begin
               start_div = 1'b1;
               start_op  = OP_MAE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            rem_in     = trial_ge ? DIVR_W'(trial - {1'b0, divisor_ff}) : trial[DIVR_W-1:0];
            dvd_in     = {dvd_ff[SQ_SUM_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               case (div_op_ff)
                  OP_AVG: begin
                     res_avg_in        = (|dvd_in[SQ_SUM_W-1:PRICE_W]) ? '1
                                                                        : dvd_in[PRICE_W-1:0];
                     forecast_in       = res_avg_in;
                     forecast_valid_in = 1'b1;
                     if (stats_ok_ff) begin
                        start_div = 1'b1;
                        start_op  = OP_MAE;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  OP_MAE: begin
                     res_mae_in = (|dvd_in[SQ_SUM_W-1:PRICE_W]) ? '1 : dvd_in[PRICE_W-1:0];
                     start_div  = 1'b1;
                     start_op   = OP_MSE;
                  end
                  default: begin
                     res_mse_in = (|dvd_in[SQ_SUM_W-1:MSE_W]) ? '1 : dvd_in[MSE_W-1:0];
                     state_in   = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               clear_series = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The dividend is loaded left-aligned so that only its own width is iterated.
      if (start_div) begin
         div_op_in = start_op;
         rem_in    = '0;
         state_in  = S_DIV;
         case (start_op)
            OP_AVG: begin
               dvd_in     = {avg_dividend, {(SQ_SUM_W - WSUM_W){1'b0}}};
               divisor_in = weighted_mode_ff ? DIVR_W'(wtot_ff) : DIVR_W'(eff_n);
               div_cnt_in = DIV_CNT_W'(WSUM_W);
            end
            OP_MAE: begin
               dvd_in     = {abs_sum_in, {(SQ_SUM_W - ABS_SUM_W){1'b0}}};
               divisor_in = DIVR_W'(pair_count_in);
               div_cnt_in = DIV_CNT_W'(ABS_SUM_W);
            end
            default: begin
               dvd_in     = sq_sum_in;
               divisor_in = DIVR_W'(pair_count_in);
               div_cnt_in = DIV_CNT_W'(SQ_SUM_W);
            end
         endcase
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_LEN: begin
               window_len_in = csr_wdata[WLEN_W-1:0];
               clear_series  = 1'b1;
            end
            CSR_WEIGHTED_MODE: begin
               weighted_mode_in = csr_wdata[0];
            end
            default: begin
               window_len_in = window_len_ff;
            end
         endcase
      end

      if (clear_series) begin
         write_slot_in     = '0;
         fill_count_in     = '0;
         plain_sum_in      = '0;
         weighted_sum_in   = '0;
         forecast_in       = '0;
         forecast_valid_in = 1'b0;
         abs_sum_in        = '0;
         sq_sum_in         = '0;
         pair_count_in     = '0;
      end
   end

   always_comb begin
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_average_in       = rsp_average_ff;
      rsp_average_valid_in = rsp_average_valid_ff;
      rsp_mae_in           = rsp_mae_ff;
      rsp_mse_in           = rsp_mse_ff;
      rsp_stats_valid_in   = rsp_stats_valid_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_average_in       = avg_ok_ff ? res_avg_ff : '0;
         rsp_average_valid_in = avg_ok_ff;
         rsp_mae_in           = stats_ok_ff ? res_mae_ff : '0;
         rsp_mse_in           = stats_ok_ff ? res_mse_ff : '0;
         rsp_stats_valid_in   = stats_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         window_len_ff     <= WLEN_W'(WINDOW_LEN_RST);
         weighted_mode_ff  <= 1'b0;
         write_slot_ff     <= '0;
         fill_count_ff     <= '0;
         plain_sum_ff      <= '0;
         weighted_sum_ff   <= '0;
         forecast_ff       <= '0;
         forecast_valid_ff <= 1'b0;
         abs_sum_ff        <= '0;
         sq_sum_ff         <= '0;
         pair_count_ff     <= '0;
         avg_ok_ff         <= 1'b0;
         stats_ok_ff       <= 1'b0;
         div_op_ff         <= OP_AVG;
         div_cnt_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         window_len_ff     <= window_len_in;
         weighted_mode_ff  <= weighted_mode_in;
         write_slot_ff     <= write_slot_in;
         fill_count_ff     <= fill_count_in;
         plain_sum_ff      <= plain_sum_in;
         weighted_sum_ff   <= weighted_sum_in;
         forecast_ff       <= forecast_in;
         forecast_valid_ff <= forecast_valid_in;
         abs_sum_ff        <= abs_sum_in;
         sq_sum_ff         <= sq_sum_in;
         pair_count_ff     <= pair_count_in;
         avg_ok_ff         <= avg_ok_in;
         stats_ok_ff       <= stats_ok_in;
         div_op_ff         <= div_op_in;
         div_cnt_ff        <= div_cnt_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff             <= price_in;
      last_ff              <= last_in;
      slot_ff              <= slot_in;
      err_ff               <= err_in;
      sq_err_ff            <= sq_err_in;
      wprod_ff             <= wprod_in;
      wtot_ff              <= wtot_in;
      dvd_ff               <= dvd_in;
      rem_ff               <= rem_in;
      divisor_ff           <= divisor_in;
      res_avg_ff           <= res_avg_in;
      res_mae_ff           <= res_mae_in;
      res_mse_ff           <= res_mse_in;
      rsp_average_ff       <= rsp_average_in;
      rsp_average_valid_ff <= rsp_average_valid_in;
      rsp_mae_ff           <= rsp_mae_in;
      rsp_mse_ff           <= rsp_mse_in;
      rsp_stats_valid_ff   <= rsp_stats_valid_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_average        = rsp_average_ff;
   assign rsp_average_valid  = rsp_average_valid_ff;
   assign rsp_mean_abs_error = rsp_mae_ff;
   assign rsp_mean_sq_error  = rsp_mse_ff;
   assign rsp_stats_valid    = rsp_stats_valid_ff;

`ifndef NO_ASSERTIONS
   // An accepted item always starts with the ring read.
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_READ))
      else $error("accepted item did not start with a ring read");

   // The divider never sits in its state with no bits left to produce.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff != '0))
      else $error("divider running with zero count");

   // The fill count never passes the ring depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(WINDOW_MAX))
      else $error("fill count beyond ring depth");

   // A new result appears only when the sequencer hands one over.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result appeared outside the output step");
`endif

endmodule
